// File: rtl/crc32fc_pkg.sv
// Shared types, constants and the byte-wide CRC-32 update for the frame checker.
// No dependencies; imported by every module of the block.
`default_nettype none

package crc32fc_pkg;

  // Largest byte count that the counter reports; longer frames saturate here.
  localparam int unsigned MAX_FRAME_BYTES = 1024;
  // Width of the internal byte counter, wide enough to hold the maximum itself.
  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  // Fixed width of the reported byte count.
  localparam int unsigned FRAME_BYTES_W = 11;
  // Number of trailing bytes that carry the CRC.
  localparam int unsigned TAIL_BYTES = 4;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Frame check outcome.
  typedef enum logic [1:0] {
    STATUS_UNCHECKED = 2'd0,
    STATUS_GOOD      = 2'd1,
    STATUS_BAD       = 2'd2
  } status_e;

  // One frame result as it travels from the check logic to the output register.
  typedef struct packed {
    status_e                    status;
    logic [FRAME_BYTES_W-1:0]   bytes;
  } result_t;

  // MSB-first CRC-32 update with one byte, eight bit steps unrolled.
  function automatic logic [31:0] crc_feed(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {b, 24'h00_0000};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/crc32fc_check.sv
// Frame state and check logic: CRC accumulator, four-byte tail window, byte counter.
// Depends on crc32fc_pkg for the CRC update, the status codes and the result type.
`default_nettype none

module crc32fc_check import crc32fc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output result_t         result_o
);

  logic [31:0]      crc_q, crc_d, crc_upd;
  logic [CNT_W-1:0] count_q, count_d, count_upd;
  logic [7:0]       win_q [TAIL_BYTES];
  logic [31:0]      got;
  status_e          status;

  // A byte enters the CRC only as it leaves a full window.
  always_comb begin
    if (count_q >= CNT_W'(TAIL_BYTES)) begin
      crc_upd = crc_feed(crc_q, win_q[0]);
    end else begin
      crc_upd = crc_q;
    end
  end

  // Saturating byte count including the current word.
  always_comb begin
    if (count_q < CNT_W'(MAX_FRAME_BYTES)) begin
      count_upd = count_q + CNT_W'(1);
    end else begin
      count_upd = count_q;
    end
  end

  // Trailing CRC after the shift, oldest byte lowest.
  assign got = {data_byte_i, win_q[3], win_q[2], win_q[1]};

  always_comb begin
    if (count_upd <= CNT_W'(TAIL_BYTES)) begin
      status = STATUS_UNCHECKED;
    end else if (got == ~crc_upd) begin
      status = STATUS_GOOD;
    end else begin
      status = STATUS_BAD;
    end
  end

  assign result_o.status = status;
  assign result_o.bytes  = FRAME_BYTES_W'(count_upd);

  // The last word of a frame restarts the accumulator and the counter.
  always_comb begin
    crc_d   = crc_q;
    count_d = count_q;
    if (fire_i) begin
      if (last_byte_i) begin
        crc_d   = CRC_INIT;
        count_d = '0;
      end else begin
        crc_d   = crc_upd;
        count_d = count_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CRC_INIT;
      count_q <= '0;
    end else begin
      crc_q   <= crc_d;
      count_q <= count_d;
    end
  end

  // The tail window is refilled before it is read, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      for (int i = 0; i < TAIL_BYTES - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[TAIL_BYTES-1] <= data_byte_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/crc32_frame_checker.sv
// Top level of the CRC-32 frame checker: input register, check logic, result register.
// Depends on crc32fc_pkg and crc32fc_check.
//
// Usage:
//   Frame bytes enter on the input channel (in_valid_i, in_stall_o, data_byte_i,
//   last_byte_i), one word per accepted handshake; last_byte_i marks the final byte.
//   The trailing four bytes of a frame are its CRC-32 (MSB-first, polynomial
//   04C11DB7, all-ones start, inverted), sent lowest byte first.
//   One result word per frame leaves on the output channel (out_valid_o,
//   out_stall_i, frame_status_o, frame_bytes_o): unchecked for frames of four
//   bytes or fewer, otherwise good or bad, with a saturating byte count.
//   The last byte of a frame is held in the input register, and the result register
//   takes the outcome once it is free.
//   Throughput: one byte per cycle while in_stall_o is low; the byte-wide CRC
//   update is combinational between the input register and the result register.
//   While the receiver stalls, bytes that produce no result keep flowing; a last
//   byte waits in the input register until the result register is free, and
//   in_stall_o rises only then.
//   Reset empties both registers, sets the accumulator to all ones and the byte
//   count to zero. The tail window needs no reset.
`default_nettype none

module crc32_frame_checker import crc32fc_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [7:0]               data_byte_i,
  input  wire logic                     last_byte_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [1:0]                    frame_status_o,
  output logic [FRAME_BYTES_W-1:0]      frame_bytes_o
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       out_free;
  logic       s1_fire;
  logic       in_accept;
  logic       out_valid_q, out_valid_d;
  result_t    result;
  result_t    result_q;

  // The result register can take a new word when empty or being drained.
  assign out_free  = !out_valid_q || !out_stall_i;
  // Bytes without a result never wait on the receiver.
  assign s1_fire   = in_valid_q && (!last_q || out_free);
  assign in_stall_o = in_valid_q && !s1_fire;
  assign in_accept = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  crc32fc_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s1_fire),
    .data_byte_i (byte_q),
    .last_byte_i (last_q),
    .result_o    (result)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = s1_fire && last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && last_q) begin
      result_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_status_o = result_q.status;
  assign frame_bytes_o  = result_q.bytes;

endmodule

`default_nettype wire

// File: rtl/crc32fc_checker.sv
// Port-level checks for the frame checker, bound to the top level.
// Depends on crc32fc_pkg and crc32_frame_checker.
`default_nettype none

module crc32fc_checker import crc32fc_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_stall_o,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic [1:0]               frame_status_o,
  input wire logic [FRAME_BYTES_W-1:0] frame_bytes_o
);

  // A stalled result word stays presented.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // Only the three defined outcomes appear.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_status_o == STATUS_UNCHECKED) ||
                    (frame_status_o == STATUS_GOOD) || (frame_status_o == STATUS_BAD))
    else $error("undefined frame status");

  // A frame has at least one byte and the count never passes its ceiling.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_bytes_o != '0) &&
                    (frame_bytes_o <= FRAME_BYTES_W'(MAX_FRAME_BYTES)))
    else $error("frame byte count out of range");

  // The CRC is checked exactly when the frame is longer than its tail.
  a_status_vs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((frame_status_o == STATUS_UNCHECKED) ==
                     (frame_bytes_o <= FRAME_BYTES_W'(TAIL_BYTES))))
    else $error("frame status disagrees with byte count");

  // The input stalls only while the receiver holds back a result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

endmodule

bind crc32_frame_checker crc32fc_checker u_crc32fc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .frame_status_o (frame_status_o),
  .frame_bytes_o  (frame_bytes_o)
);

`default_nettype wire
